>>> src/assert_macros.svh
// Shared assertion macros for the generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/mt_pkg.sv
package mt_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned WORDS       = 624;
    localparam int unsigned SHIFT       = 397;
    localparam int unsigned ADDR_W      = $clog2(WORDS);
    localparam int unsigned POS_W       = 10;

    localparam t_word TW_XOR_WORD  = 32'h9908_b0df;
    localparam t_word TW_HI_MASK   = 32'h8000_0000;
    localparam t_word TW_LO_MASK   = 32'h7fff_ffff;
    localparam t_word INIT_MUL     = 32'd1812433253;
    localparam t_word TEMPER_B     = 32'h9d2c_5680;
    localparam t_word TEMPER_C     = 32'hefc6_0000;
    localparam t_word DEFAULT_SEED = 32'd5489;

    localparam logic [POS_W-1:0] POS_UNINIT = POS_W'(WORDS + 1);
    localparam logic [POS_W-1:0] POS_FULL   = POS_W'(WORDS);

    function automatic t_word temper(input t_word y_in);
        t_word y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> src/mersenne_twister_generator_top.sv
// MT19937 pseudo-random word source.
// Input channel (i_valid / o_ready, i_reseed): one transfer requests one word.
// Output channel (o_valid / i_ready, o_random_word): one tempered word per request.
// Seed channel (i_cfg_valid / o_cfg_ready, i_cfg_seed): always ready; the seed
// takes effect at the next state initialization.
// Sequence per request:
//   plain draw: read the word at the current position, then temper it into the
//   output register; no new request is taken until the result is registered.
//   twist (every 624th word): three reads/writes per state word on the 624x32
//   state RAM (read next, read far, write back), done before the draw.
//   initialization (first request after reset, or any request with i_reseed):
//   the seed is written as word 0, each further word passes the seed multiplier, then a full twist.
// Reset: the seed returns to 5489 and the state is marked uninitialized; the RAM
// is not cleared, since initialization writes every word before any read.
// A stalled receiver holds the result in the output register; the next request
// may be taken meanwhile and waits in its final step until the register drains.
module mersenne_twister_generator_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_reseed,
    output logic           o_valid,
    input  logic           i_ready,
    output mt_pkg::t_word  o_random_word,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  mt_pkg::t_word  i_cfg_seed
);
    import mt_pkg::*;
    `include "assert_macros.svh"

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FILL0    = 4'd1;
    localparam logic [3:0] S_FILL_MUL = 4'd2;
    localparam logic [3:0] S_FILL_ADD = 4'd3;
    localparam logic [3:0] S_TW_RD0   = 4'd4;
    localparam logic [3:0] S_TW_CUR   = 4'd5;
    localparam logic [3:0] S_TW_RDN   = 4'd6;
    localparam logic [3:0] S_TW_RDF   = 4'd7;
    localparam logic [3:0] S_TW_WR    = 4'd8;
    localparam logic [3:0] S_DR_RD    = 4'd9;
    localparam logic [3:0] S_DR_OUT   = 4'd10;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(WORDS - 1);

    logic [3:0]        r_state, n_state;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0] r_idx, n_idx;
    t_word             r_seed;
    t_word             r_p, n_p;
    t_word             r_prod, n_prod;
    t_word             r_cur, n_cur;
    t_word             r_nxt, n_nxt;
    t_word             r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    t_word             wr_data, rd_data;
    logic [ADDR_W-1:0] idx_next, idx_far;
    t_word             fill_word, tw_y, tw_word;
    logic              in_xfer, out_free;

    mt_ram #(
        .WIDTH ($bits(t_word)),
        .DEPTH (WORDS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_random_word = r_out;
    assign in_xfer       = i_valid && o_ready;
    assign out_free      = !r_out_valid || i_ready;

    // neighbor and far taps of the twist, wrapped around the state ring
    assign idx_next = (r_idx == LAST_IDX) ? '0 : r_idx + ADDR_W'(1);
    assign idx_far  = (r_idx < ADDR_W'(WORDS - SHIFT)) ? r_idx + ADDR_W'(SHIFT)
                                                         : r_idx - ADDR_W'(WORDS - SHIFT);

    assign fill_word = r_prod + t_word'(r_idx);
    assign tw_y      = (r_cur & TW_HI_MASK) | (r_nxt & TW_LO_MASK);
    assign tw_word   = rd_data ^ (tw_y >> 1) ^ (tw_y[0] ? TW_XOR_WORD : '0);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_p         = r_p;
        n_prod      = r_prod;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = fill_word;
        rd_en       = 1'b0;
        rd_addr     = r_idx;

        // drop the result once the receiver takes it
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_reseed || (r_pos == POS_UNINIT)) begin
                        n_state = S_FILL0;
                    end else if (r_pos >= POS_FULL) begin
                        n_state = S_TW_RD0;
                    end else begin
                        n_state = S_DR_RD;
                    end
                end
            end
            S_FILL0: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_seed;
                n_p     = r_seed;
                n_idx   = ADDR_W'(1);
                n_state = S_FILL_MUL;
            end
            S_FILL_MUL: begin
                n_prod  = t_word'((r_p ^ (r_p >> 30)) * INIT_MUL);
                n_state = S_FILL_ADD;
            end
            S_FILL_ADD: begin
                wr_en = 1'b1;
                n_p   = fill_word;
                if (r_idx == LAST_IDX) begin
                    n_state = S_TW_RD0;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = S_FILL_MUL;
                end
            end
            S_TW_RD0: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_idx   = '0;
                n_state = S_TW_CUR;
            end
            S_TW_CUR: begin
                n_cur   = rd_data;
                n_state = S_TW_RDN;
            end
            S_TW_RDN: begin
                rd_en   = 1'b1;
                rd_addr = idx_next;
                n_state = S_TW_RDF;
            end
            S_TW_RDF: begin
                n_nxt   = rd_data;
                rd_en   = 1'b1;
                rd_addr = idx_far;
                n_state = S_TW_WR;
            end
            S_TW_WR: begin
                // write back in place; later taps see the new words as the ring demands
                wr_en   = 1'b1;
                wr_data = tw_word;
                n_cur   = r_nxt;
                if (r_idx == LAST_IDX) begin
                    n_pos   = '0;
                    n_state = S_DR_RD;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = S_TW_RDN;
                end
            end
            S_DR_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_pos[ADDR_W-1:0];
                n_state = S_DR_OUT;
            end
            S_DR_OUT: begin
                // hold here until the output register is free
                if (out_free) begin
                    n_out       = temper(rd_data);
                    n_out_valid = 1'b1;
                    n_pos       = r_pos + POS_W'(1);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= POS_UNINIT;
            r_seed      <= DEFAULT_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_seed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_p    <= n_p;
        r_prod <= n_prod;
        r_cur  <= n_cur;
        r_nxt  <= n_nxt;
        r_out  <= n_out;
    end

    `ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, r_state != S_IDLE)
    `ASSERT_SAME(a_draw_in_range, i_clk, i_rst_n, r_state == S_DR_RD, r_pos < POS_FULL)
    `ASSERT_NEXT(a_stalled_result_kept, i_clk, i_rst_n,
                 (r_state == S_DR_OUT) && r_out_valid && !i_ready, r_out_valid)
    `ASSERT_NEXT(a_twist_ends_at_zero, i_clk, i_rst_n,
                 (r_state == S_TW_WR) && (r_idx == LAST_IDX),
                 (r_state == S_DR_RD) && (r_pos == '0))

endmodule

>>> src/mt_ram.sv
module mt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold read data while no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
